// File: rtl/ptc_pkg.sv
`timescale 1ns / 1ps

package ptc_pkg;

    // Calibration register indexes
    typedef enum logic [2:0] {
        REG_FACTORY   = 3'd0,
        REG_SENS      = 3'd1,
        REG_OFFSET    = 3'd2,
        REG_SENS_TEMP = 3'd3,
        REG_OFF_TEMP  = 3'd4,
        REG_REF_TEMP  = 3'd5,
        REG_TEMP_SLOPE = 3'd6,
        REG_CRC       = 3'd7
    } ptc_reg_t;

    localparam int NUM_REGS = 8;

    localparam logic [15:0] CRC_POLY = 16'h3000;

    // Status of the CRC unit as seen by the datapath
    typedef struct packed {
        logic busy;
        logic ok;
    } ptc_crc_stat_t;

    // Fold one byte into the CRC remainder, eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] rem, input logic [7:0] data);
        logic [15:0] r;
        r = rem ^ {8'h00, data};
        for (int j = 0; j < 8; j++)
        begin
            if (r[15])
            begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/ptc_crc.sv
`timescale 1ns / 1ps

module ptc_crc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic [15:0]           words [ptc_pkg::NUM_REGS],
    output ptc_pkg::ptc_crc_stat_t stat
);

    logic        run_reg, run_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic        ok_reg, ok_next;
    logic [15:0] word;
    logic [7:0]  data;
    logic [15:0] rem_step;

    // Pick the byte for this step, most significant byte first
    always_comb
    begin
        word = words[cnt_reg[3:1]];
        if (cnt_reg[3:1] == ptc_pkg::REG_CRC)
        begin
            word = {word[15:8], 8'h00};
        end
        data = cnt_reg[0] ? word[7:0] : word[15:8];
        rem_step = ptc_pkg::crc_byte(rem_reg, data);
    end

    // Advance one byte per cycle; restart on any calibration write
    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        ok_next  = ok_reg;
        if (restart)
        begin
            run_next = 1'b1;
            cnt_next = 4'd0;
            rem_next = 16'h0000;
        end
        else if (run_reg)
        begin
            rem_next = rem_step;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'hF)
            begin
                run_next = 1'b0;
                ok_next  = (rem_step[15:12] == words[ptc_pkg::REG_CRC][3:0]);
            end
        end
    end

    // All-zero calibration words give a matching CRC, so reset to ok
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 4'd0;
            rem_reg <= 16'h0000;
            ok_reg  <= 1'b1;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            ok_reg  <= ok_next;
        end
    end

    assign stat.busy = run_reg;
    assign stat.ok   = ok_reg;

endmodule

// File: rtl/pressure_temperature_compensation.sv
`timescale 1ns / 1ps

// Throughput: one item per cycle while busy is low, through a six-stage multiply pipeline.
// After every calibration write busy is high while the CRC unit
// walks the 16 calibration bytes, one byte per cycle; no item is taken then.
// Reset clears valid bits and all calibration registers; the CRC status resets to ok.
// Results cannot be stalled: done marks each result for one cycle.
module pressure_temperature_compensation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [23:0]        raw_press,
    input  logic [23:0]        raw_temp,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output logic               done,
    output logic signed [18:0] temp_centi,
    output logic signed [22:0] press_centi,
    output logic               calib_ok
);

    logic [15:0] cal_reg [ptc_pkg::NUM_REGS];
    ptc_pkg::ptc_crc_stat_t crc_stat;
    logic accept;

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, done_reg;

    // Stage payloads
    logic [23:0]        d1_s1_reg, d1_s2_reg, d1_s3_reg;
    logic signed [24:0] dt_reg, dt_next;
    logic signed [41:0] p6_reg, p4_reg, p3_reg;
    logic signed [41:0] p6_next, p4_next, p3_next;
    logic signed [18:0] temp_s3_reg, temp_s4_reg, temp_s5_reg, temp_next;
    logic signed [36:0] off_s3_reg, off_s4_reg, off_s5_reg, off_next;
    logic signed [34:0] sens_reg, sens_next;
    logic [40:0]        pl_reg, pl_next;
    logic signed [42:0] ph_reg, ph_next;
    logic signed [59:0] prod;
    logic signed [38:0] q_reg, q_next;
    logic signed [39:0] diff;
    logic signed [18:0] temp_out_reg;
    logic signed [22:0] press_out_reg, press_next;
    logic               ok_out_reg;

    assign busy   = crc_stat.busy;
    assign accept = start && !crc_stat.busy;

    // Calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ptc_pkg::NUM_REGS; i++)
            begin
                cal_reg[i] <= 16'h0000;
            end
        end
        else if (cfg_we)
        begin
            cal_reg[cfg_index] <= cfg_wdata;
        end
    end

    ptc_crc u_crc (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .words   (cal_reg),
        .stat    (crc_stat)
    );

    // Stage 1: temperature difference dT = D2 - C5*256
    assign dt_next = $signed({1'b0, raw_temp})
                   - $signed({1'b0, cal_reg[ptc_pkg::REG_REF_TEMP], 8'h00});

    // Stage 2: coefficient products with dT
    assign p6_next = $signed({1'b0, cal_reg[ptc_pkg::REG_TEMP_SLOPE]}) * dt_reg;
    assign p4_next = $signed({1'b0, cal_reg[ptc_pkg::REG_OFF_TEMP]}) * dt_reg;
    assign p3_next = $signed({1'b0, cal_reg[ptc_pkg::REG_SENS_TEMP]}) * dt_reg;

    // Stage 3: temperature, offset and sensitivity
    assign temp_next = p6_reg[41:23] + 19'sd2000;
    assign off_next  = $signed({4'b0000, cal_reg[ptc_pkg::REG_OFFSET], 17'h00000})
                     + {p4_reg[41], p4_reg[41:6]};
    assign sens_next = $signed({3'b000, cal_reg[ptc_pkg::REG_SENS], 16'h0000})
                     + p3_reg[41:7];

    // Stage 4: D1 * SENS split into two partial products
    assign pl_next = d1_s3_reg * sens_reg[16:0];
    assign ph_next = $signed({1'b0, d1_s3_reg}) * $signed(sens_reg[34:17]);

    // Stage 5: combine partial products and drop 21 bits
    assign prod   = $signed({ph_reg, 17'h00000}) + $signed({19'h00000, pl_reg});
    assign q_next = prod[59:21];

    // Stage 6: subtract offset and drop 15 bits
    assign diff       = $signed({q_reg[38], q_reg}) - $signed({{3{off_s5_reg[36]}}, off_s5_reg});
    assign press_next = diff[37:15];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d1_s1_reg <= raw_press;
            dt_reg    <= dt_next;
        end
        if (v1_reg)
        begin
            d1_s2_reg <= d1_s1_reg;
            p6_reg    <= p6_next;
            p4_reg    <= p4_next;
            p3_reg    <= p3_next;
        end
        if (v2_reg)
        begin
            d1_s3_reg   <= d1_s2_reg;
            temp_s3_reg <= temp_next;
            off_s3_reg  <= off_next;
            sens_reg    <= sens_next;
        end
        if (v3_reg)
        begin
            temp_s4_reg <= temp_s3_reg;
            off_s4_reg  <= off_s3_reg;
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
        end
        if (v4_reg)
        begin
            temp_s5_reg <= temp_s4_reg;
            off_s5_reg  <= off_s4_reg;
            q_reg       <= q_next;
        end
        if (v5_reg)
        begin
            temp_out_reg  <= temp_s5_reg;
            press_out_reg <= press_next;
            ok_out_reg    <= crc_stat.ok;
        end
    end

    assign done        = done_reg;
    assign temp_centi  = temp_out_reg;
    assign press_centi = press_out_reg;
    assign calib_ok    = ok_out_reg;

endmodule

// File: rtl/ptc_checker.sv
`timescale 1ns / 1ps

module ptc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cfg_we,
    input logic done
);

    // A calibration write holds off items while the CRC is recomputed
    a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("busy not raised after calibration write");

    // Every accepted item yields a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted item produced no result");

    // No result appears without an earlier accepted item
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without accepted item");

    // The CRC pass does not end as soon as busy rises
    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) && !cfg_we |=> busy)
        else $error("busy dropped right after rising");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cfg_we (cfg_we),
    .done   (done)
);

// File: tb/sv/tb_pressure_temperature_compensation.sv
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation;

    localparam int LATENCY         = 6;
    localparam int QUIET_LIMIT     = 4000;
    localparam int PHASE_COUNT     = 10;
    localparam int ITEMS_PER_PHASE = 190;

    typedef struct {
        logic [23:0] press;
        logic [23:0] temp;
    } raw_pair_t;

    typedef struct {
        logic signed [18:0] temp;
        logic signed [22:0] press;
        logic               ok;
    } reading_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [23:0]        raw_press = '0;
    logic [23:0]        raw_temp = '0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               done;
    logic signed [18:0] temp_centi;
    logic signed [22:0] press_centi;
    logic               calib_ok;

    // Calibration words as the block should hold them
    logic [15:0] cal_regs [ptc_pkg::NUM_REGS];

    raw_pair_t pending_pairs [$];
    reading_t  expected_readings [$];
    raw_pair_t next_pair;
    reading_t  oldest_reading;

    int   idle_pct = 0;
    int   pairs_queued = 0;
    int   pairs_taken = 0;
    int   errors = 0;
    int   quiet_cycles = 0;
    logic took = 1'b0;

    pressure_temperature_compensation dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .raw_press   (raw_press),
        .raw_temp    (raw_temp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .temp_centi  (temp_centi),
        .press_centi (press_centi),
        .calib_ok    (calib_ok)
    );

    always #2 clk = ~clk;

    // CRC4 over the sixteen calibration bytes, high byte first, low byte of word seven as zero
    function automatic logic [3:0] calib_crc4(input logic [15:0] words [ptc_pkg::NUM_REGS]);
        logic [15:0] rem;
        logic [7:0]  b;
        rem = '0;
        for (int i = 0; i < 2 * ptc_pkg::NUM_REGS; i++)
        begin
            b = i[0] ? words[i >> 1][7:0] : words[i >> 1][15:8];
            if (i == 2 * ptc_pkg::NUM_REGS - 1)
            begin
                b = 8'h00;
            end
            rem = rem ^ {8'h00, b};
            for (int j = 0; j < 8; j++)
            begin
                rem = rem[15] ? ({rem[14:0], 1'b0} ^ ptc_pkg::CRC_POLY) : {rem[14:0], 1'b0};
            end
        end
        return rem[15:12];
    endfunction

    // First-order compensation with floor shifts on signed 64-bit values
    function automatic reading_t compensate(input logic [23:0] d1, input logic [23:0] d2);
        longint   dt;
        longint   temp;
        longint   off;
        longint   sens;
        longint   press;
        reading_t r;
        dt    = longint'(d2) - longint'(cal_regs[ptc_pkg::REG_REF_TEMP]) * 256;
        temp  = 2000 + ((longint'(cal_regs[ptc_pkg::REG_TEMP_SLOPE]) * dt) >>> 23);
        off   = longint'(cal_regs[ptc_pkg::REG_OFFSET]) * 131072
              + ((longint'(cal_regs[ptc_pkg::REG_OFF_TEMP]) * dt) >>> 6);
        sens  = longint'(cal_regs[ptc_pkg::REG_SENS]) * 65536
              + ((longint'(cal_regs[ptc_pkg::REG_SENS_TEMP]) * dt) >>> 7);
        press = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
        r.temp  = temp[18:0];
        r.press = press[22:0];
        r.ok    = (calib_crc4(cal_regs) == cal_regs[ptc_pkg::REG_CRC][3:0]);
        return r;
    endfunction

    // Raw value: extremes, near the reference temperature, or anything
    function automatic logic [23:0] pick_raw();
        longint v;
        case ($urandom_range(9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2:
            begin
                v = longint'(cal_regs[ptc_pkg::REG_REF_TEMP]) * 256 + $urandom_range(64) - 32;
                if (v < 0)
                begin
                    v = 0;
                end
                if (v > 24'hFFFFFF)
                begin
                    v = 24'hFFFFFF;
                end
                return v[23:0];
            end
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic queue_pair(input logic [23:0] d1, input logic [23:0] d2);
        raw_pair_t p;
        p.press = d1;
        p.temp  = d2;
        pending_pairs.push_back(p);
        pairs_queued++;
    endtask

    // Hold until every item is taken and every reading is back, then let the pipe empty
    task automatic wait_drained();
        while (pairs_taken != pairs_queued || expected_readings.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // Write all eight words; the CRC nibble is made to match half the time
    task automatic write_calibration(input int mode);
        logic [15:0] words [ptc_pkg::NUM_REGS];
        for (int i = 0; i < ptc_pkg::NUM_REGS; i++)
        begin
            case (mode)
                0: words[i] = 16'h0000;
                1: words[i] = 16'hFFFF;
                2: words[i] = 16'($urandom());
                default:
                begin
                    case ($urandom_range(3))
                        0: words[i] = 16'h0000;
                        1: words[i] = 16'hFFFF;
                        default: words[i] = 16'($urandom());
                    endcase
                end
            endcase
        end
        if ($urandom_range(1) == 1)
        begin
            words[ptc_pkg::REG_CRC][3:0] = calib_crc4(words);
        end
        for (int i = 0; i < ptc_pkg::NUM_REGS; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= ptc_pkg::ptc_reg_t'(i);
            cfg_wdata <= words[i];
            cal_regs[i] = words[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drive the next item, or idle, once the current one is taken
    always @(negedge clk)
    begin
        if (!start || took)
        begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                next_pair = pending_pairs.pop_front();
                start     <= 1'b1;
                raw_press <= next_pair.press;
                raw_temp  <= next_pair.temp;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Check readings, predict for taken items, watch for a hang
    always @(posedge clk)
    begin
        took <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("reading with no item outstanding");
                    errors++;
                end
                else
                begin
                    oldest_reading = expected_readings.pop_front();
                    if (temp_centi !== oldest_reading.temp)
                    begin
                        $error("temp_centi mismatch: expected %0d, got %0d",
                               oldest_reading.temp, temp_centi);
                        errors++;
                    end
                    if (press_centi !== oldest_reading.press)
                    begin
                        $error("press_centi mismatch: expected %0d, got %0d",
                               oldest_reading.press, press_centi);
                        errors++;
                    end
                    if (calib_ok !== oldest_reading.ok)
                    begin
                        $error("calib_ok mismatch: expected %0d, got %0d",
                               oldest_reading.ok, calib_ok);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_readings.push_back(compensate(raw_press, raw_temp));
                pairs_taken++;
            end
            if (done || (start && !busy))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // Phases of calibration settings and sender idling
    initial
    begin
        int idle_by_phase [4];
        int mode;
        idle_by_phase = '{0, 81, 0, 28};
        for (int i = 0; i < ptc_pkg::NUM_REGS; i++)
        begin
            cal_regs[i] = 16'h0000;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                mode = (phase == 1) ? 1 : (phase == 2) ? 0 : (phase < 6) ? 2 : 3;
                write_calibration(mode);
            end
            idle_pct = idle_by_phase[phase % 4];
            @(posedge clk);

            // Reset calibration: zero and full-scale raw values
            if (phase == 0)
            begin
                queue_pair(24'h000000, 24'h000000);
                queue_pair(24'hFFFFFF, 24'hFFFFFF);
                queue_pair(24'h000000, 24'hFFFFFF);
                queue_pair(24'hFFFFFF, 24'h000000);
            end
            // Full-scale calibration: extremes, mid-scale and the reference temperature
            if (phase == 1)
            begin
                queue_pair(24'h000000, 24'h000000);
                queue_pair(24'hFFFFFF, 24'hFFFFFF);
                queue_pair(24'h000000, 24'hFFFFFF);
                queue_pair(24'hFFFFFF, 24'h000000);
                queue_pair(24'h800000, 24'h800000);
                queue_pair(24'h7FFFFF, 24'h7FFFFF);
                queue_pair(24'hFFFFFF, 24'hFFFF00);
                queue_pair(24'hFFFFFF, 24'hFFFEFF);
                queue_pair(24'hAAAAAA, 24'h555555);
                queue_pair(24'h555555, 24'hAAAAAA);
            end
            repeat (ITEMS_PER_PHASE) queue_pair(pick_raw(), pick_raw());
        end

        wait_drained();
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/ptc_pkg.sv
rtl/ptc_crc.sv
rtl/pressure_temperature_compensation.sv
rtl/ptc_checker.sv
tb/sv/tb_pressure_temperature_compensation.sv
